[sv/csv_quoted_field_splitter_core_defines.svh]
// Assertion macros shared by the splitter RTL.
`ifndef CSV_QUOTED_FIELD_SPLITTER_CORE_DEFINES_SVH
`define CSV_QUOTED_FIELD_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CSVQS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CSVQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/csvqs_pkg.sv]
package csvqs_pkg;

   localparam logic [7:0] QUOTE_BYTE = 8'h22;
   localparam logic [7:0] CR_BYTE    = 8'h0D;
   localparam logic [7:0] BOM_BYTE0  = 8'hEF;
   localparam logic [7:0] BOM_BYTE1  = 8'hBB;
   localparam logic [7:0] BOM_BYTE2  = 8'hBF;

   localparam logic [7:0] FIELD_SEP_RESET  = 8'd44;
   localparam logic [7:0] RECORD_SEP_RESET = 8'd10;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_SEP  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_SEP = 8'd1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic       in_quotes;
      logic       quote_pending;
      logic       cr_held;
      logic       field_has_bytes;
      logic       record_has_bytes;
      logic [1:0] bom_position;
      logic       bom_done;
      logic [1:0] stream_position_small;
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       field_end;
      logic       record_end;
      logic       bom_seen;
      logic       stream_error;
      logic       last;
   } result_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_APPEND,
      ACT_END_FIELD,
      ACT_END_RECORD
   } action_type;

   // results of one step, in order
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } step_out_type;

   function automatic logic [7:0] bom_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0:    b = BOM_BYTE0;
         2'd1:    b = BOM_BYTE1;
         2'd2:    b = BOM_BYTE2;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic result_type make_result(input logic [7:0] data, input logic valid,
                                              input logic fe, input logic re,
                                              input logic bom, input logic err);
      result_type r;
      r.data_byte    = data;
      r.byte_valid   = valid;
      r.field_end    = fe;
      r.record_end   = re;
      r.bom_seen     = bom;
      r.stream_error = err;
      r.last         = 1'b0;
      return r;
   endfunction

endpackage

[sv/csvqs_step.sv]
module csvqs_step (
   input  csvqs_pkg::state_type    state_cur,
   input  logic                    kind,
   input  logic [7:0]              in_byte,
   input  logic [7:0]              field_sep,
   input  logic [7:0]              record_sep,
   output csvqs_pkg::state_type    state_next,
   output csvqs_pkg::step_out_type step_out
);

   csvqs_pkg::state_type  pre;
   csvqs_pkg::action_type act;
   csvqs_pkg::result_type res0;
   csvqs_pkg::result_type res1;
   logic [1:0]            n;
   logic [1:0]            pos;
   logic                  escaped_quote;
   logic                  bom_hit;

   assign pos           = state_cur.stream_position_small;
   assign escaped_quote = state_cur.quote_pending && (in_byte == csvqs_pkg::QUOTE_BYTE);
   assign bom_hit       = !state_cur.bom_done && (pos != 2'd3) &&
                          (state_cur.bom_position == pos) &&
                          (in_byte == csvqs_pkg::bom_byte(pos));

   // Decide what the byte does; quote and BOM bookkeeping happen here.
   always_comb begin
      pre = state_cur;
      act = csvqs_pkg::ACT_NONE;
      if (!kind) begin
         if (pos != 2'd3) begin
            pre.stream_position_small = pos + 2'd1;
         end
         if (state_cur.quote_pending) begin
            pre.quote_pending = 1'b0;
            if (escaped_quote) begin
               act = csvqs_pkg::ACT_APPEND;
            end else begin
               pre.in_quotes = 1'b0;
            end
         end
         if (!escaped_quote) begin
            if (in_byte == record_sep) begin
               act = pre.in_quotes ? csvqs_pkg::ACT_APPEND : csvqs_pkg::ACT_END_RECORD;
            end else if (in_byte == csvqs_pkg::QUOTE_BYTE) begin
               if (pre.in_quotes) begin
                  pre.quote_pending = 1'b1;
               end else begin
                  pre.in_quotes = 1'b1;
               end
            end else if (bom_hit) begin
               pre.bom_position = state_cur.bom_position + 2'd1;
               if (state_cur.bom_position == 2'd2) begin
                  pre.bom_done = 1'b1;
               end
            end else if ((in_byte == field_sep) && !pre.in_quotes) begin
               act = csvqs_pkg::ACT_END_FIELD;
            end else begin
               act = csvqs_pkg::ACT_APPEND;
            end
         end
      end
   end

   // Build the results and the remaining state update.
   always_comb begin
      state_next = pre;
      n          = 2'd0;
      res0       = '0;
      res1       = '0;
      if (kind) begin
         if (state_cur.quote_pending) begin
            res0 = csvqs_pkg::make_result(8'h00, 1'b0, 1'b0, 1'b1,
                                          state_cur.bom_done, 1'b1);
            n    = 2'd1;
         end else if (state_cur.record_has_bytes) begin
            res0 = csvqs_pkg::make_result(8'h00, 1'b0, state_cur.field_has_bytes, 1'b1,
                                          state_cur.bom_done, 1'b0);
            n    = 2'd1;
         end
         state_next = '0;
      end else begin
         unique case (act)
            csvqs_pkg::ACT_APPEND: begin
               // a held CR goes out ahead of the new byte
               if (pre.cr_held) begin
                  res0                        = csvqs_pkg::make_result(
                     csvqs_pkg::CR_BYTE, 1'b1, 1'b0, 1'b0, pre.bom_done, 1'b0);
                  n                           = 2'd1;
                  state_next.cr_held          = 1'b0;
                  state_next.field_has_bytes  = 1'b1;
                  state_next.record_has_bytes = 1'b1;
               end
               if (in_byte == csvqs_pkg::CR_BYTE) begin
                  state_next.cr_held = 1'b1;
               end else begin
                  if (pre.cr_held) begin
                     res1 = csvqs_pkg::make_result(in_byte, 1'b1, 1'b0, 1'b0,
                                                   pre.bom_done, 1'b0);
                     n    = 2'd2;
                  end else begin
                     res0 = csvqs_pkg::make_result(in_byte, 1'b1, 1'b0, 1'b0,
                                                   pre.bom_done, 1'b0);
                     n    = 2'd1;
                  end
                  state_next.field_has_bytes  = 1'b1;
                  state_next.record_has_bytes = 1'b1;
               end
            end
            csvqs_pkg::ACT_END_FIELD: begin
               if (pre.cr_held) begin
                  res0 = csvqs_pkg::make_result(csvqs_pkg::CR_BYTE, 1'b1, 1'b1, 1'b0,
                                                pre.bom_done, 1'b0);
               end else begin
                  res0 = csvqs_pkg::make_result(8'h00, 1'b0, 1'b1, 1'b0,
                                                pre.bom_done, 1'b0);
               end
               n                           = 2'd1;
               state_next.cr_held          = 1'b0;
               state_next.field_has_bytes  = 1'b0;
               state_next.record_has_bytes = 1'b1;
            end
            csvqs_pkg::ACT_END_RECORD: begin
               // held CR is dropped; empty records give nothing
               if (pre.record_has_bytes) begin
                  res0 = csvqs_pkg::make_result(8'h00, 1'b0, pre.field_has_bytes, 1'b1,
                                                pre.bom_done, 1'b0);
                  n    = 2'd1;
               end
               state_next.cr_held          = 1'b0;
               state_next.field_has_bytes  = 1'b0;
               state_next.record_has_bytes = 1'b0;
               state_next.in_quotes        = 1'b0;
               state_next.quote_pending    = 1'b0;
            end
            default: begin
            end
         endcase
      end
      if (n == 2'd1) begin
         res0.last = 1'b1;
      end
      if (n == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   assign step_out.count = n;
   assign step_out.res0  = res0;
   assign step_out.res1  = res1;

endmodule

[sv/csvqs_rsp_fifo.sv]
`include "csv_quoted_field_splitter_core_defines.svh"

module csvqs_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        push_n,
   input  csvqs_pkg::result_type             push0,
   input  csvqs_pkg::result_type             push1,
   input  logic                              pop,
   output csvqs_pkg::result_type             head,
   output logic                              not_empty,
   output logic                              room2
);

   csvqs_pkg::result_type            mem [csvqs_pkg::FIFO_DEPTH];
   logic [csvqs_pkg::FIFO_AW-1:0]    wr_ff;
   logic [csvqs_pkg::FIFO_AW-1:0]    wr_in;
   logic [csvqs_pkg::FIFO_AW-1:0]    wr_next_slot;
   logic [csvqs_pkg::FIFO_AW-1:0]    rd_ff;
   logic [csvqs_pkg::FIFO_AW-1:0]    rd_in;
   logic [csvqs_pkg::FIFO_CW-1:0]    cnt_ff;
   logic [csvqs_pkg::FIFO_CW-1:0]    cnt_in;

   assign wr_next_slot = wr_ff + csvqs_pkg::FIFO_AW'(1);
   assign wr_in        = wr_ff + csvqs_pkg::FIFO_AW'(push_n);
   assign rd_in        = rd_ff + csvqs_pkg::FIFO_AW'(pop);
   assign cnt_in       = cnt_ff + csvqs_pkg::FIFO_CW'(push_n) - csvqs_pkg::FIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem[wr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         mem[wr_next_slot] <= push1;
      end
   end

   assign head      = mem[rd_ff];
   assign not_empty = (cnt_ff != '0);
   // two free slots needed: one item can yield two results
   assign room2     = (cnt_ff <= csvqs_pkg::FIFO_CW'(csvqs_pkg::FIFO_DEPTH - 2));

   `CSVQS_ASSERT_IMPL(a_fifo_bound, 1'b1, cnt_ff <= csvqs_pkg::FIFO_CW'(csvqs_pkg::FIFO_DEPTH), "result queue count beyond depth")
   `CSVQS_ASSERT_IMPL(a_fifo_no_overflow, push_n != 2'd0, cnt_in <= csvqs_pkg::FIFO_CW'(csvqs_pkg::FIFO_DEPTH), "result queue overflow")
   `CSVQS_ASSERT_NEXT(a_fifo_drain, pop && (push_n == 2'd0), cnt_ff == csvqs_pkg::FIFO_CW'($past(cnt_ff) - 1'b1), "pop did not lower count")

endmodule

[sv/csv_quoted_field_splitter_core.sv]
// CSV splitter with RFC 4180 quoting: takes one byte (or an end-of-stream item) per req
// transfer and gives field bytes with field-end and record-end marks on rsp. A byte is
// accepted every cycle while req_ready is high; its state update is a single pass of logic
// between the parser state register and a four-entry result queue. Most bytes give zero or
// one result; a content byte other than CR that releases a held CR gives two. req_ready
// drops only while the queue holds more than two results. csr writes are always taken, as
// csr_ready is tied high, and must only be issued while the block is idle; indexes other
// than 0 and 1 are ignored.
`include "csv_quoted_field_splitter_core_defines.svh"

module csv_quoted_field_splitter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [7:0]                      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_data_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_field_end,
   output logic                            rsp_record_end,
   output logic                            rsp_bom_seen,
   output logic                            rsp_stream_error,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [csvqs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                      csr_data
);

   csvqs_pkg::state_type    state_ff;
   csvqs_pkg::state_type    state_in;
   csvqs_pkg::step_out_type step_out;
   csvqs_pkg::result_type   head;
   logic [7:0]              field_sep_ff;
   logic [7:0]              record_sep_ff;
   logic                    req_xfer;
   logic                    pop;
   logic                    not_empty;
   logic                    room2;
   logic [1:0]              push_n;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_sep_ff  <= csvqs_pkg::FIELD_SEP_RESET;
         record_sep_ff <= csvqs_pkg::RECORD_SEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            csvqs_pkg::CSR_FIELD_SEP:  field_sep_ff  <= csr_data;
            csvqs_pkg::CSR_RECORD_SEP: record_sep_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_ready = room2;
   assign req_xfer  = req_valid && req_ready;

   csvqs_step u_step (
      .state_cur  (state_ff),
      .kind       (req_kind),
      .in_byte    (req_in_byte),
      .field_sep  (field_sep_ff),
      .record_sep (record_sep_ff),
      .state_next (state_in),
      .step_out   (step_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   assign push_n = req_xfer ? step_out.count : 2'd0;
   assign pop    = rsp_valid && rsp_ready;

   csvqs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push0     (step_out.res0),
      .push1     (step_out.res1),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .room2     (room2)
   );

   assign rsp_valid        = not_empty;
   assign rsp_data_byte    = head.data_byte;
   assign rsp_byte_valid   = head.byte_valid;
   assign rsp_field_end    = head.field_end;
   assign rsp_record_end   = head.record_end;
   assign rsp_bom_seen     = head.bom_seen;
   assign rsp_stream_error = head.stream_error;
   assign rsp_last         = head.last;

   `CSVQS_ASSERT_NEXT(a_eos_clears_state, req_xfer && req_kind, state_ff == '0, "state not cleared after end of stream")
   `CSVQS_ASSERT_IMPL(a_two_results_last, step_out.count == 2'd2, !step_out.res0.last && step_out.res1.last, "last mark misplaced on two-result item")
   `CSVQS_ASSERT_IMPL(a_error_ends_record, rsp_valid && rsp_stream_error, rsp_record_end && rsp_last && !rsp_byte_valid, "error result without record end")

endmodule
